### src/bhrt_pkg.sv
// ============================================================================
// bhrt_pkg
// Shared types, constants and helpers of the button hold/repeat tracker.
// ============================================================================
package bhrt_pkg;

    // Number of live buttons; lanes at or above it stay idle.
    localparam int BUTTON_COUNT = 8;
    localparam int MAX_LANES    = 8;
    localparam int LANE_W       = $clog2(MAX_LANES);
    localparam int CNT_W        = 16;

    localparam logic [CNT_W-1:0] CNT_MAX      = 16'hFFFD;
    localparam logic [CNT_W-1:0] CNT_RELEASED = 16'hFFFF;

    localparam logic [MAX_LANES-1:0] LANE_MASK =
        MAX_LANES'((17'd1 << BUTTON_COUNT) - 17'd1);

    // Dividend bits consumed per cycle by the modulo unit
    localparam int MOD_BITS_PER_STEP = 4;
    localparam int MOD_STEPS         = CNT_W / MOD_BITS_PER_STEP;
    localparam int MOD_STEP_W        = $clog2(MOD_STEPS);

    // Configuration register indexes
    localparam logic CFG_HOLD_TIME     = 1'b0;
    localparam logic CFG_REPEAT_PERIOD = 1'b1;

    // One frame as handed from the front to the back
    typedef struct packed {
        logic [MAX_LANES-1:0] down;    // 1 = button pressed, unused lanes cleared
        logic [LANE_W-1:0]    query;
    } item_t;

    // One result; packs straight onto the output tdata (pressed in the LSBs)
    typedef struct packed {
        logic [CNT_W-1:0]     time_held;
        logic [MAX_LANES-1:0] repeat_mask;
        logic [MAX_LANES-1:0] held_mask;
        logic [MAX_LANES-1:0] released_mask;
        logic [MAX_LANES-1:0] pressed_mask;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_WAIT,
        ST_EMIT
    } back_state_t;

    function automatic logic [CNT_W-1:0] next_count(input logic [CNT_W-1:0] c,
                                                    input logic down);
        logic [CNT_W-1:0] n;
        if (down) begin
            if (c == CNT_RELEASED)
                n = CNT_W'(1);
            else if (c < CNT_MAX)
                n = c + CNT_W'(1);
            else
                n = c;
        end
        else if (c == '0 || c == CNT_RELEASED) begin
            n = '0;
        end
        else begin
            n = CNT_RELEASED;
        end
        return n;
    endfunction

endpackage

### src/bhrt_front.sv
// ============================================================================
// bhrt_front
// Input side: decodes the button byte into a pressed mask and queues frames.
// ============================================================================
module bhrt_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           raw_buttons,
    input  logic [2:0]           query_button,
    output logic                 q_valid,
    input  logic                 q_pop,
    output bhrt_pkg::item_t      q_item
);

    bhrt_pkg::item_t mem_reg [2];
    logic            wptr_reg, wptr_next;
    logic            rptr_reg, rptr_next;
    logic [1:0]      fill_reg, fill_next;
    logic            push, pop;
    bhrt_pkg::item_t item_in;

    // Active-low levels to a pressed mask; dead lanes never count
    assign item_in.down  = ~raw_buttons & bhrt_pkg::LANE_MASK;
    assign item_in.query = query_button;

    assign in_ready = (fill_reg != 2'd2);
    assign q_valid  = (fill_reg != 2'd0);
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;
    assign q_item   = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next = push ? ~wptr_reg : wptr_reg;
        rptr_next = pop  ? ~rptr_reg : rptr_reg;
        fill_next = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= item_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

endmodule

### src/bhrt_mod.sv
// ============================================================================
// bhrt_mod
// Iterative 16-bit by 8-bit remainder, four dividend bits per cycle.
// ============================================================================
module bhrt_mod (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [7:0]  divisor,
    output logic        done,
    output logic [7:0]  rem
);

    logic [15:0]                          div_reg, div_next;
    logic [7:0]                           rem_reg, rem_next;
    logic [bhrt_pkg::MOD_STEP_W-1:0]      step_reg;
    logic                                 busy_reg;
    logic                                 last_step;

    // Restoring steps; a zero divisor gives junk that the caller ignores
    always_comb
    begin
        logic [8:0]  t;
        logic [7:0]  r;
        logic [15:0] d;
        r = rem_reg;
        d = div_reg;
        for (int i = 0; i < bhrt_pkg::MOD_BITS_PER_STEP; i++)
        begin
            t = {r, d[15]};
            d = {d[14:0], 1'b0};
            if (t >= {1'b0, divisor})
                t = t - {1'b0, divisor};
            r = t[7:0];
        end
        rem_next = r;
        div_next = d;
    end

    assign last_step = (step_reg == bhrt_pkg::MOD_STEP_W'(bhrt_pkg::MOD_STEPS - 1));
    assign rem       = rem_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            div_reg <= div_next;
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            done     <= 1'b0;
        end
        else
        begin
            done <= busy_reg && last_step && !start;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (last_step)
                    busy_reg <= 1'b0;
            end
        end
    end

endmodule

### src/bhrt_back.sv
// ============================================================================
// bhrt_back
// Counter update, per-lane repeat sequencing and the result register.
// ============================================================================
module bhrt_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           hold_time,
    input  logic [7:0]           repeat_period,
    input  logic                 q_valid,
    output logic                 q_pop,
    input  bhrt_pkg::item_t      q_item,
    output logic                 res_valid,
    input  logic                 res_ready,
    output bhrt_pkg::result_t    res_data
);

    localparam int LW = bhrt_pkg::LANE_W;
    localparam int NL = bhrt_pkg::MAX_LANES;

    bhrt_pkg::back_state_t          state_reg, state_next;
    logic [bhrt_pkg::CNT_W-1:0]     cnt_reg  [NL];
    logic [bhrt_pkg::CNT_W-1:0]     cnt_next [NL];
    logic [LW-1:0]                  lane_reg;
    logic [LW-1:0]                  mod_lane;
    logic [LW-1:0]                  query_reg;
    logic [NL-1:0]                  rep_reg;
    logic                           mod_start, mod_done;
    logic [7:0]                     mod_rem;
    logic                           last_lane;
    logic                           load_item, emit;
    logic                           rep_bit;
    logic [bhrt_pkg::CNT_W-1:0]     cur_cnt;
    logic [bhrt_pkg::CNT_W-1:0]     hold_cmp;
    logic [bhrt_pkg::CNT_W-1:0]     q_cnt;
    bhrt_pkg::result_t              result;

    assign last_lane = (lane_reg == LW'(bhrt_pkg::BUTTON_COUNT - 1));
    assign cur_cnt   = cnt_reg[lane_reg];

    // The next lane's remainder starts in the cycle the current one finishes
    assign mod_lane  = (state_reg == bhrt_pkg::ST_WAIT) ? LW'(lane_reg + 1'b1) : lane_reg;

    bhrt_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (cnt_reg[mod_lane]),
        .divisor  (repeat_period),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bhrt_pkg::ST_IDLE:
                if (q_valid)
                    state_next = bhrt_pkg::ST_START;
            bhrt_pkg::ST_START:
                state_next = bhrt_pkg::ST_WAIT;
            bhrt_pkg::ST_WAIT:
                if (mod_done && last_lane)
                    state_next = bhrt_pkg::ST_EMIT;
            bhrt_pkg::ST_EMIT:
                if (!res_valid || res_ready)
                    state_next = bhrt_pkg::ST_IDLE;
            default:
                state_next = bhrt_pkg::ST_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        load_item = 1'b0;
        mod_start = 1'b0;
        emit      = 1'b0;
        case (state_reg)
            bhrt_pkg::ST_IDLE:  load_item = q_valid;
            bhrt_pkg::ST_START: mod_start = 1'b1;
            bhrt_pkg::ST_WAIT:  mod_start = mod_done && !last_lane;
            bhrt_pkg::ST_EMIT:  emit      = !res_valid || res_ready;
            default:            load_item = 1'b0;
        endcase
    end

    assign q_pop = load_item;

    always_comb
    begin
        for (int b = 0; b < NL; b++)
        begin
            if (b < bhrt_pkg::BUTTON_COUNT)
                cnt_next[b] = bhrt_pkg::next_count(cnt_reg[b], q_item.down[b]);
            else
                cnt_next[b] = '0;
        end
    end

    // Repeat on any live count; with a period above one, only at remainder one
    assign rep_bit = (cur_cnt != '0) && (cur_cnt != bhrt_pkg::CNT_RELEASED) &&
                     ((repeat_period <= 8'd1) || (mod_rem == 8'd1));

    assign hold_cmp = bhrt_pkg::CNT_W'(hold_time) + bhrt_pkg::CNT_W'(1);
    assign q_cnt    = cnt_reg[query_reg];

    always_comb
    begin
        for (int b = 0; b < NL; b++)
        begin
            result.pressed_mask[b]  = (cnt_reg[b] == bhrt_pkg::CNT_W'(1));
            result.released_mask[b] = (cnt_reg[b] == bhrt_pkg::CNT_RELEASED);
            result.held_mask[b]     = (cnt_reg[b] == hold_cmp);
        end
        result.repeat_mask = rep_reg;
        if ((4'(query_reg) < 4'(bhrt_pkg::BUTTON_COUNT)) &&
            (q_cnt != bhrt_pkg::CNT_RELEASED))
            result.time_held = q_cnt;
        else
            result.time_held = '0;
    end

    always_ff @(posedge clk)
    begin
        if (load_item)
            query_reg <= q_item.query;
        if (emit)
            res_data <= result;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bhrt_pkg::ST_IDLE;
            lane_reg  <= '0;
            rep_reg   <= '0;
            res_valid <= 1'b0;
            for (int b = 0; b < NL; b++)
                cnt_reg[b] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_item)
            begin
                for (int b = 0; b < NL; b++)
                    cnt_reg[b] <= cnt_next[b];
                lane_reg <= '0;
                rep_reg  <= '0;
            end
            else if (state_reg == bhrt_pkg::ST_WAIT && mod_done)
            begin
                rep_reg[lane_reg] <= rep_bit;
                if (!last_lane)
                    lane_reg <= lane_reg + 1'b1;
            end
            if (emit)
                res_valid <= 1'b1;
            else if (res_ready)
                res_valid <= 1'b0;
        end
    end

endmodule

### src/button_hold_repeat_tracker_top.sv
// ============================================================================
// button_hold_repeat_tracker_top
// Per-button hold counters with press, release, hold and auto-repeat events.
// ============================================================================
// One input transfer per frame carries the active-low button byte and the
// index of the button whose held time is wanted; exactly one output transfer
// follows with the pressed, released, held and repeat masks and that time.
// The repeat mask needs a counter-mod-period remainder per button, and one
// shared modulo unit walks the buttons in turn at four dividend bits a cycle,
// starting each button's remainder as the last one finishes; a frame is taken,
// its first remainder started, the remainders worked through and then the
// result register loaded, one frame at a time.
// A two-entry queue behind the input and a result register in front of the
// output decouple the two sides until the queue fills. Configuration
// writes (index 0 hold_time, index 1 repeat_period, both reset to 1) are
// always taken and should only be issued while no frame is in flight.
// ============================================================================
module button_hold_repeat_tracker_top (
    input  logic        clk,
    input  logic        rst_n,
    // Input frame stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [7:0] raw_buttons, [10:8] query_button, rest zero
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // [7:0] pressed_mask, [15:8] released_mask,
                                    // [23:16] held_mask, [31:24] repeat_mask,
                                    // [47:32] time_held
    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_data
);

    logic [7:0]         hold_time_reg;
    logic [7:0]         repeat_period_reg;
    logic               q_valid;
    logic               q_pop;
    bhrt_pkg::item_t    q_item;
    bhrt_pkg::result_t  res_data;

    // Register file: a write is a transfer on the config channel
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_time_reg     <= 8'd1;
            repeat_period_reg <= 8'd1;
        end
        else if (cfg_valid)
        begin
            case (cfg_addr)
                bhrt_pkg::CFG_HOLD_TIME:     hold_time_reg     <= cfg_data;
                bhrt_pkg::CFG_REPEAT_PERIOD: repeat_period_reg <= cfg_data;
                default:                     hold_time_reg     <= hold_time_reg;
            endcase
        end
    end

    // Front: decode and queue incoming frames
    bhrt_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .raw_buttons  (s_tdata[7:0]),
        .query_button (s_tdata[10:8]),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_item       (q_item)
    );

    // Back: counters, repeat sequencing, result register
    bhrt_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .hold_time     (hold_time_reg),
        .repeat_period (repeat_period_reg),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_item        (q_item),
        .res_valid     (m_tvalid),
        .res_ready     (m_tready),
        .res_data      (res_data)
    );

    assign m_tdata = res_data;

endmodule

### tb/tb_button_hold_repeat_tracker_top.sv
// ============================================================================
// tb_button_hold_repeat_tracker_top
// Self-checking bench for the button hold/repeat tracker.
// ============================================================================
// Frames go in on the s_* stream and one result per frame comes back on m_*.
// A class keeps its own copy of the eight hold counters and both registers.
// It predicts the four masks and the held time of every accepted frame, and
// checks each result transfer field by field against the oldest prediction.
// Stimulus: a short directed list, then random phases under several register
// settings, the extremes among them. The random frames are built from press
// and release runs of random length, with some noise frames mixed in. A final
// long press on one button runs it through its held and repeat counts.
// ============================================================================
module tb_button_hold_repeat_tracker_top;

    // Frame latency bound used before register writes and at the end
    localparam int LAT_CYCLES  = 5 * bhrt_pkg::BUTTON_COUNT + 8;
    localparam int CYCLE_LIMIT = 8_000_000;
    // Frames of the closing long press on button 0
    localparam int SAT_FRAMES  = 30;

    // ------------------------------------------------------------------------
    // Predictor: hold counters, registers and the results still due
    // ------------------------------------------------------------------------
    class hold_tracker;
        logic [bhrt_pkg::CNT_W-1:0] lane_cnt [bhrt_pkg::MAX_LANES];
        logic [7:0]                 hold_time;
        logic [7:0]                 repeat_period;
        bhrt_pkg::result_t          due_results [$];
        int                         errors;

        function new();
            foreach (lane_cnt[i]) lane_cnt[i] = '0;
            hold_time     = 8'd1;
            repeat_period = 8'd1;
            errors        = 0;
        endfunction

        function void set_reg(logic idx, logic [7:0] val);
            if (idx == bhrt_pkg::CFG_HOLD_TIME)
                hold_time = val;
            else
                repeat_period = val;
        endfunction

        // Advance every live lane by one frame and queue the result it gives
        function void take_frame(logic [7:0] raw, logic [2:0] query);
            bhrt_pkg::result_t          r;
            logic [bhrt_pkg::CNT_W-1:0] c;
            r = '0;
            for (int b = 0; b < bhrt_pkg::BUTTON_COUNT; b++)
            begin
                c = lane_cnt[b];
                if (!raw[b])
                begin
                    // a press on the release marker starts a new press
                    if (c == bhrt_pkg::CNT_RELEASED)
                        c = bhrt_pkg::CNT_W'(1);
                    else if (c < bhrt_pkg::CNT_MAX)
                        c = c + bhrt_pkg::CNT_W'(1);
                end
                else if (c == '0 || c == bhrt_pkg::CNT_RELEASED)
                    c = '0;
                else
                    c = bhrt_pkg::CNT_RELEASED;
                lane_cnt[b] = c;

                r.pressed_mask[b]  = (c == bhrt_pkg::CNT_W'(1));
                r.released_mask[b] = (c == bhrt_pkg::CNT_RELEASED);
                // wide compare: hold_time 255 matches a count of 256
                r.held_mask[b]     = (int'(c) == int'(hold_time) + 1);
                if (c != '0 && c != bhrt_pkg::CNT_RELEASED)
                    r.repeat_mask[b] = (repeat_period <= 8'd1) ||
                                       (int'(c) % int'(repeat_period) == 1);
            end
            if (int'(query) < bhrt_pkg::BUTTON_COUNT)
                r.time_held = (lane_cnt[query] == bhrt_pkg::CNT_RELEASED) ?
                              '0 : lane_cnt[query];
            due_results.push_back(r);
        endfunction

        function void match_result(bhrt_pkg::result_t got);
            bhrt_pkg::result_t want;
            if (due_results.size() == 0)
            begin
                $error("result with nothing due: %h", got);
                errors++;
                return;
            end
            want = due_results.pop_front();
            if (got.pressed_mask !== want.pressed_mask)
            begin
                $error("pressed_mask: expected %h, actual %h",
                       want.pressed_mask, got.pressed_mask);
                errors++;
            end
            if (got.released_mask !== want.released_mask)
            begin
                $error("released_mask: expected %h, actual %h",
                       want.released_mask, got.released_mask);
                errors++;
            end
            if (got.held_mask !== want.held_mask)
            begin
                $error("held_mask: expected %h, actual %h",
                       want.held_mask, got.held_mask);
                errors++;
            end
            if (got.repeat_mask !== want.repeat_mask)
            begin
                $error("repeat_mask: expected %h, actual %h",
                       want.repeat_mask, got.repeat_mask);
                errors++;
            end
            if (got.time_held !== want.time_held)
            begin
                $error("time_held: expected %0d, actual %0d",
                       want.time_held, got.time_held);
                errors++;
            end
        endfunction

        function int due_count();
            return due_results.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT and its signals
    // ------------------------------------------------------------------------
    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;      // [7:0] raw_buttons, [10:8] query_button
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;      // pressed, released, held, repeat masks, time_held
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_addr;
    logic [7:0]  cfg_data;

    button_hold_repeat_tracker_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    hold_tracker tracker;

    // Idle rates in percent; hold_left forces a long receiver stall
    int tx_idle_pct = 27;
    int rx_idle_pct = 63;
    int hold_left   = 0;
    int cycles      = 0;

    // Per-button run generator: current level, frames left, long-run flag
    int run_left [bhrt_pkg::MAX_LANES];
    bit run_down [bhrt_pkg::MAX_LANES];
    bit run_long [bhrt_pkg::MAX_LANES];
    int long_lo  = 2;
    int long_hi  = 9;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: ready changes at the falling edge only
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Result transfers are taken at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.match_result(bhrt_pkg::result_t'(m_tdata));
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Next button byte from the run generator. Short press runs mostly, now
    // and then a long one that reaches the held and repeat counts. Releases
    // of one frame give a press right after the release marker.
    function logic [7:0] next_buttons();
        logic [7:0] raw;
        logic [7:0] noise;
        raw = '1;
        for (int b = 0; b < bhrt_pkg::MAX_LANES; b++)
        begin
            if (run_left[b] == 0)
            begin
                run_down[b] = !run_down[b];
                run_long[b] = 1'b0;
                if (!run_down[b])
                    run_left[b] = $urandom_range(3, 1);
                else if ($urandom_range(7) == 0)
                begin
                    run_left[b] = $urandom_range(long_hi, long_lo);
                    run_long[b] = 1'b1;
                end
                else
                    run_left[b] = $urandom_range(6, 1);
            end
            run_left[b]--;
            raw[b] = !run_down[b];
        end
        // noise flips random short-run lanes, long runs stay intact
        if ($urandom_range(9) == 0)
        begin
            noise = 8'($urandom);
            for (int b = 0; b < bhrt_pkg::MAX_LANES; b++)
                if (run_long[b])
                    noise[b] = 1'b0;
            raw = raw ^ noise;
        end
        return raw;
    endfunction

    // One frame transfer. Starts at a falling edge, ends at the falling edge
    // after acceptance with valid still high; the caller's next step drives it.
    task send_frame(input logic [7:0] raw, input logic [2:0] query);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, query, raw};
        do
            @(posedge clk);
        while (!s_tready);
        tracker.take_frame(raw, query);
        @(negedge clk);
    endtask

    // Stop offering frames until every result is in, then let the block settle
    task wait_idle();
        s_tvalid <= 1'b0;
        while (tracker.due_count() != 0)
            @(negedge clk);
        repeat (LAT_CYCLES) @(negedge clk);
    endtask

    task write_reg(input logic idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        tracker.set_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Random phase under one register setting; stall_at >= 0 starts a long
    // receiver hold-off at that frame so the input side backs up.
    task run_phase(input logic [7:0] ht, input logic [7:0] rp, input int n,
                   input int stall_at);
        wait_idle();
        write_reg(bhrt_pkg::CFG_HOLD_TIME, ht);
        write_reg(bhrt_pkg::CFG_REPEAT_PERIOD, rp);
        long_lo = int'(ht) + 1;
        long_hi = ((ht > rp) ? int'(ht) : int'(rp)) + 8;
        for (int i = 0; i < n; i++)
        begin
            if (i == stall_at)
                hold_left = 600;
            send_frame(next_buttons(), 3'($urandom_range(7)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [7:0] sat_raw;
        tracker   = new();
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_addr  = 1'b0;
        cfg_data  = '0;
        foreach (run_left[i])
        begin
            run_left[i] = 0;
            run_down[i] = 1'b0;
            run_long[i] = 1'b0;
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed frames at reset settings (hold 1, repeat every frame)
        send_frame(8'hFF, 3'd0);           // all idle
        send_frame(8'h00, 3'd0);           // all pressed at once
        send_frame(8'h00, 3'd7);           // count 2: held fires
        send_frame(8'h00, 3'd1);
        send_frame(8'hFF, 3'd3);           // release marker, time_held 0
        send_frame(8'h00, 3'd3);           // press straight after release
        send_frame(8'hFF, 3'd4);
        send_frame(8'hFF, 3'd5);           // marker then back to idle
        send_frame(8'hAA, 3'd6);
        send_frame(8'h55, 3'd2);
        send_frame(8'hAA, 3'd1);
        send_frame(8'h55, 3'd5);
        for (int b = 0; b < bhrt_pkg::MAX_LANES; b++)
            send_frame(~(8'h01 << b), 3'(b));

        // Sender 27 / receiver 63 percent idle
        tx_idle_pct = 27;
        rx_idle_pct = 63;
        run_phase(8'd0,   8'd0,   100, 40);
        run_phase(8'd255, 8'd255, 300, -1);
        run_phase(8'd254, 8'd2,   300, -1);

        // Swapped idle rates
        tx_idle_pct = 63;
        rx_idle_pct = 27;
        run_phase(8'd1,   8'd1,   100, -1);
        run_phase(8'd5,   8'd3,   100, -1);
        run_phase(8'd2,   8'd254, 100, -1);

        // No idling
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_phase(8'($urandom_range(254, 1)), 8'($urandom_range(254)), 100, -1);
        run_phase(8'd3,   8'd0,   100, -1);

        // Button 0 held through its held count and several repeat periods
        wait_idle();
        write_reg(bhrt_pkg::CFG_HOLD_TIME, 8'd4);
        write_reg(bhrt_pkg::CFG_REPEAT_PERIOD, 8'd7);
        long_lo = 5;
        long_hi = 15;
        for (int i = 0; i < SAT_FRAMES; i++)
        begin
            sat_raw    = next_buttons();
            sat_raw[0] = 1'b0;
            send_frame(sat_raw, $urandom_range(1) ? 3'd0 : 3'($urandom_range(7)));
        end
        for (int i = 0; i < 20; i++)
            send_frame(next_buttons(), 3'($urandom_range(7)));

        wait_idle();
        if (tracker.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
